/* rtl/smie_pkg.sv */
`timescale 1ns / 1ps
// Shared opcodes, error codes and controller/datapath interface types for
// the stack machine instruction executor. No dependencies.
package smie_pkg;

  // Instruction opcodes.
  localparam logic [7:0] OP_HALT  = 8'd0;
  localparam logic [7:0] OP_PUSHC = 8'd1;
  localparam logic [7:0] OP_ADD   = 8'd2;
  localparam logic [7:0] OP_SUB   = 8'd3;
  localparam logic [7:0] OP_MUL   = 8'd4;
  localparam logic [7:0] OP_DIV   = 8'd5;
  localparam logic [7:0] OP_MOD   = 8'd6;
  localparam logic [7:0] OP_RDINT = 8'd7;
  localparam logic [7:0] OP_WRINT = 8'd8;
  localparam logic [7:0] OP_RDCHR = 8'd9;
  localparam logic [7:0] OP_WRCHR = 8'd10;
  localparam logic [7:0] OP_PUSHG = 8'd11;
  localparam logic [7:0] OP_POPG  = 8'd12;
  localparam logic [7:0] OP_ASF   = 8'd13;
  localparam logic [7:0] OP_RSF   = 8'd14;
  localparam logic [7:0] OP_PUSHL = 8'd15;
  localparam logic [7:0] OP_POPL  = 8'd16;
  localparam logic [7:0] OP_EQ    = 8'd17;
  localparam logic [7:0] OP_NE    = 8'd18;
  localparam logic [7:0] OP_LT    = 8'd19;
  localparam logic [7:0] OP_LE    = 8'd20;
  localparam logic [7:0] OP_GT    = 8'd21;
  localparam logic [7:0] OP_GE    = 8'd22;
  localparam logic [7:0] OP_JMP   = 8'd23;
  localparam logic [7:0] OP_BRF   = 8'd24;
  localparam logic [7:0] OP_BRT   = 8'd25;

  // Error codes.
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_DIVZ  = 3'd1;
  localparam logic [2:0] ERR_OVF   = 3'd2;
  localparam logic [2:0] ERR_UNF   = 3'd3;
  localparam logic [2:0] ERR_GLOB  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clearing;
    logic load;
    logic rd_b;
    logic cap_a;
    logic cap_b;
    logic exec;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic div_needed;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

/* rtl/smie_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/smie_div.sv */
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing else.
module smie_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] divs;
  logic [31:0] rem;
  logic [31:0] quo;
  logic        neg_q;
  logic        neg_r;
  logic [32:0] shifted;
  logic [33:0] trial;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign shifted = {rem, quo[31]};
  assign trial   = {1'b0, shifted} - {2'b00, divs};

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Magnitude datapath; signs are applied at the outputs.
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend[31] ? (32'd0 - dividend) : dividend;
      divs  <= divisor[31] ? (32'd0 - divisor) : divisor;
      rem   <= '0;
      neg_q <= dividend[31] ^ divisor[31];
      neg_r <= dividend[31];
    end else if (busy) begin
      if (!trial[33]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient  = neg_q ? (32'd0 - quo) : quo;
  assign remainder = neg_r ? (32'd0 - rem) : rem;
endmodule

/* rtl/smie_datapath.sv */
`timescale 1ns / 1ps
// Datapath: machine registers, stack and global memories, ALU, divider and
// the result register. Depends on smie_pkg, smie_ram and smie_div.
module smie_datapath #(
  parameter int STACK_DEPTH  = 1024,
  parameter int GLOBAL_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  smie_pkg::cmd_t     cmd,
  output smie_pkg::status_t  status,
  input  logic [7:0]         mode,
  input  logic [23:0]        immediate,
  input  logic [31:0]        console_value,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [23:0]        next_pc,
  output logic               out_valid,
  output logic [31:0]        out_value,
  output logic               out_is_char,
  output logic               halted,
  output logic [2:0]         error_code
);
  import smie_pkg::*;

  localparam int SPW  = $clog2(STACK_DEPTH + 1);
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int GW   = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;
  localparam int MAXD = (STACK_DEPTH > GLOBAL_DEPTH) ? STACK_DEPTH : GLOBAL_DEPTH;
  localparam int CW   = $clog2(MAXD);
  localparam int WW   = SPW + 26;
  localparam logic signed [WW-1:0] DEPTH_W = WW'(STACK_DEPTH);

  // Instruction and machine registers.
  logic [7:0]     opcode;
  logic [23:0]    imm;
  logic [31:0]    cv;
  logic [23:0]    pc;
  logic [SPW-1:0] sp;
  logic [SPW-1:0] fp;
  logic           halted_flag;
  logic [31:0]    a;
  logic [31:0]    b;
  logic [31:0]    g;
  logic [31:0]    r;
  logic [CW-1:0]  clr_cnt;

  // Memory ports.
  logic           st_we_mem;
  logic [AW-1:0]  st_waddr_mem;
  logic [31:0]    st_wdata_mem;
  logic [AW-1:0]  st_raddr;
  logic [31:0]    st_rdata;
  logic           gl_we_mem;
  logic [GW-1:0]  gl_waddr_mem;
  logic [31:0]    gl_wdata_mem;
  logic [31:0]    gl_rdata;

  // Divider.
  logic        div_done;
  logic [31:0] quotient;
  logic [31:0] remainder;

  // Decoded effects of the current instruction.
  logic [SPW-1:0]        sp_m1;
  logic [SPW-1:0]        sp_m2;
  logic [SPW-1:0]        fp_m1;
  logic signed [WW-1:0]  spw;
  logic signed [WW-1:0]  fpw;
  logic signed [WW-1:0]  immw;
  logic signed [WW-1:0]  nsp;
  logic signed [WW-1:0]  idx;
  logic                  sp_full;
  logic                  g_ok;
  logic                  is_divmod;
  logic [31:0]           alu;
  logic [2:0]            err;
  logic                  st_we;
  logic [AW-1:0]         st_waddr;
  logic [31:0]           st_wdata;
  logic                  gl_we;
  logic [SPW-1:0]        sp_n;
  logic [SPW-1:0]        fp_n;
  logic [23:0]           pc_n;
  logic                  ov;
  logic [31:0]           oval;
  logic                  ochar;
  logic                  halt_set;
  logic                  res_valid;
  logic                  apply;

  // Pointer arithmetic in a width that cannot overflow.
  assign sp_m1     = sp - SPW'(1);
  assign sp_m2     = sp - SPW'(2);
  assign fp_m1     = fp - SPW'(1);
  assign spw       = $signed({{(WW - SPW){1'b0}}, sp});
  assign fpw       = $signed({{(WW - SPW){1'b0}}, fp});
  assign immw      = WW'($signed(imm));
  assign nsp       = spw + immw + WW'(1);
  assign idx       = fpw + immw;
  assign sp_full   = ({1'b0, sp} >= (SPW + 1)'(STACK_DEPTH));
  assign g_ok      = !imm[23] && (imm < 24'(GLOBAL_DEPTH));
  assign is_divmod = (opcode == OP_DIV) || (opcode == OP_MOD);

  // Stack read address: the second operand on the second read cycle.
  always_comb begin
    if (cmd.rd_b) begin
      st_raddr = sp_m2[AW-1:0];
    end else begin
      case (opcode)
        OP_RSF:   st_raddr = fp_m1[AW-1:0];
        OP_PUSHL: st_raddr = idx[AW-1:0];
        default:  st_raddr = sp_m1[AW-1:0];
      endcase
    end
  end

  // ALU: a is the top of stack, b the one below it.
  always_comb begin
    case (opcode)
      OP_ADD:  alu = b + a;
      OP_SUB:  alu = b - a;
      OP_MUL:  alu = b * a;
      OP_EQ:   alu = {31'd0, (b == a)};
      OP_NE:   alu = {31'd0, (b != a)};
      OP_LT:   alu = {31'd0, ($signed(b) < $signed(a))};
      OP_LE:   alu = {31'd0, ($signed(b) <= $signed(a))};
      OP_GT:   alu = {31'd0, ($signed(b) > $signed(a))};
      OP_GE:   alu = {31'd0, ($signed(b) >= $signed(a))};
      default: alu = '0;
    endcase
  end

  // Instruction decode: checks, memory writes and next register values.
  always_comb begin
    err      = ERR_NONE;
    st_we    = 1'b0;
    st_waddr = sp[AW-1:0];
    st_wdata = a;
    gl_we    = 1'b0;
    sp_n     = sp;
    fp_n     = fp;
    pc_n     = pc + 24'd1;
    ov       = 1'b0;
    oval     = '0;
    ochar    = 1'b0;
    halt_set = 1'b0;
    case (opcode)
      OP_HALT: begin
        halt_set = 1'b1;
      end
      OP_PUSHC, OP_RDINT, OP_RDCHR: begin
        if (sp_full) begin
          err = ERR_OVF;
        end else begin
          st_we = 1'b1;
          sp_n  = sp + SPW'(1);
          if (opcode == OP_RDINT) begin
            st_wdata = cv;
          end else if (opcode == OP_RDCHR) begin
            st_wdata = {{24{cv[7]}}, cv[7:0]};
          end else begin
            st_wdata = 32'($signed(imm));
          end
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
      OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
        if (sp < SPW'(2)) begin
          err = ERR_UNF;
        end else if (is_divmod && (a == 32'd0)) begin
          err = ERR_DIVZ;
        end else begin
          st_we    = 1'b1;
          st_waddr = sp_m2[AW-1:0];
          st_wdata = r;
          sp_n     = sp_m1;
        end
      end
      OP_WRINT, OP_WRCHR: begin
        if (sp == '0) begin
          err = ERR_UNF;
        end else begin
          sp_n  = sp_m1;
          ov    = 1'b1;
          ochar = (opcode == OP_WRCHR);
          oval  = ochar ? {24'd0, a[7:0]} : a;
        end
      end
      OP_PUSHG: begin
        if (!g_ok) begin
          err = ERR_GLOB;
        end else if (sp_full) begin
          err = ERR_OVF;
        end else begin
          st_we    = 1'b1;
          st_wdata = g;
          sp_n     = sp + SPW'(1);
        end
      end
      OP_POPG: begin
        if (sp == '0) begin
          err = ERR_UNF;
        end else if (!g_ok) begin
          err = ERR_GLOB;
        end else begin
          gl_we = 1'b1;
          sp_n  = sp_m1;
        end
      end
      OP_ASF: begin
        if (sp_full) begin
          err = ERR_OVF;
        end else if (nsp > DEPTH_W) begin
          err = ERR_OVF;
        end else if (nsp < 0) begin
          err = ERR_UNF;
        end else begin
          st_we    = 1'b1;
          st_wdata = {{(32 - SPW){1'b0}}, fp};
          fp_n     = sp + SPW'(1);
          sp_n     = nsp[SPW-1:0];
        end
      end
      OP_RSF: begin
        if (fp == '0) begin
          err = ERR_UNF;
        end else if (a[31]) begin
          err = ERR_UNF;
        end else if (a > 32'(STACK_DEPTH)) begin
          err = ERR_OVF;
        end else begin
          sp_n = fp_m1;
          fp_n = a[SPW-1:0];
        end
      end
      OP_PUSHL: begin
        if (sp_full) begin
          err = ERR_OVF;
        end else if (idx < 0) begin
          err = ERR_UNF;
        end else if (idx >= DEPTH_W) begin
          err = ERR_OVF;
        end else begin
          st_we = 1'b1;
          sp_n  = sp + SPW'(1);
        end
      end
      OP_POPL: begin
        if (sp == '0) begin
          err = ERR_UNF;
        end else if (idx < 0) begin
          err = ERR_UNF;
        end else if (idx >= DEPTH_W) begin
          err = ERR_OVF;
        end else begin
          st_we    = 1'b1;
          st_waddr = idx[AW-1:0];
          sp_n     = sp_m1;
        end
      end
      OP_JMP: begin
        pc_n = imm;
      end
      OP_BRF, OP_BRT: begin
        if (sp == '0) begin
          err = ERR_UNF;
        end else begin
          sp_n = sp_m1;
          if (((opcode == OP_BRF) && (a == 32'd0)) || ((opcode == OP_BRT) && (a == 32'd1))) begin
            pc_n = imm;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Effects are applied only when the machine runs and the check passes.
  assign apply = cmd.commit && !halted_flag && (err == ERR_NONE);

  // Memory write ports, shared with the clearing pass after reset.
  always_comb begin
    if (cmd.clearing) begin
      st_we_mem    = ({1'b0, clr_cnt} < (CW + 1)'(STACK_DEPTH));
      st_waddr_mem = clr_cnt[AW-1:0];
      st_wdata_mem = '0;
      gl_we_mem    = ({1'b0, clr_cnt} < (CW + 1)'(GLOBAL_DEPTH));
      gl_waddr_mem = clr_cnt[GW-1:0];
      gl_wdata_mem = '0;
    end else begin
      st_we_mem    = apply && st_we;
      st_waddr_mem = st_waddr;
      st_wdata_mem = st_wdata;
      gl_we_mem    = apply && gl_we;
      gl_waddr_mem = imm[GW-1:0];
      gl_wdata_mem = a;
    end
  end

  smie_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (st_we_mem),
    .waddr (st_waddr_mem),
    .wdata (st_wdata_mem),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  smie_ram #(.WIDTH(32), .DEPTH(GLOBAL_DEPTH)) u_global (
    .clk   (clk),
    .we    (gl_we_mem),
    .waddr (gl_waddr_mem),
    .wdata (gl_wdata_mem),
    .raddr (imm[GW-1:0]),
    .rdata (gl_rdata)
  );

  smie_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.exec && status.div_needed),
    .dividend  (b),
    .divisor   (a),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Status back to the controller.
  assign status.clear_last = (clr_cnt == CW'(MAXD - 1));
  assign status.div_needed = is_divmod && (sp >= SPW'(2)) && (a != 32'd0) && !halted_flag;
  assign status.div_done   = div_done;
  assign status.out_free   = !res_valid || result_ready;

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clearing) begin
      clr_cnt <= clr_cnt + CW'(1);
    end
  end

  // Request capture, operand capture and ALU result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode <= mode;
      imm    <= immediate;
      cv     <= console_value;
    end
    if (cmd.cap_a) begin
      a <= st_rdata;
      g <= gl_rdata;
    end
    if (cmd.cap_b) begin
      b <= st_rdata;
    end
    if (cmd.exec) begin
      r <= alu;
    end else if (div_done) begin
      r <= (opcode == OP_DIV) ? quotient : remainder;
    end
  end

  // Machine state update at commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= '0;
      sp          <= '0;
      fp          <= '0;
      halted_flag <= 1'b0;
    end else if (cmd.commit && !halted_flag) begin
      pc <= pc_n;
      if (err != ERR_NONE) begin
        halted_flag <= 1'b1;
      end else begin
        sp          <= sp_n;
        fp          <= fp_n;
        halted_flag <= halt_set;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (result_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      next_pc     <= halted_flag ? pc : pc_n;
      out_valid   <= apply && ov;
      out_value   <= apply ? oval : 32'd0;
      out_is_char <= apply && ochar;
      halted      <= halted_flag || halt_set || (err != ERR_NONE);
      error_code  <= halted_flag ? ERR_NONE : err;
    end
  end

  assign result_valid = res_valid;
endmodule

/* rtl/smie_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: sequences memory clearing, operand reads,
// execution, division wait and commit. Depends on smie_pkg.
module smie_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  smie_pkg::status_t  status,
  output smie_pkg::cmd_t     cmd
);
  import smie_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_RDA   = 8'b00000100,
    S_RDB   = 8'b00001000,
    S_CAPB  = 8'b00010000,
    S_EXEC  = 8'b00100000,
    S_DIV   = 8'b01000000,
    S_WB    = 8'b10000000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (status.clear_last) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_RDA;
      S_RDA:   state_next = S_RDB;
      S_RDB:   state_next = S_CAPB;
      S_CAPB:  state_next = S_EXEC;
      S_EXEC:  state_next = status.div_needed ? S_DIV : S_WB;
      S_DIV:   if (status.div_done) state_next = S_WB;
      S_WB:    if (status.out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Commands to the datapath.
  assign in_ready     = (state == S_IDLE);
  assign cmd.clearing = (state == S_CLEAR);
  assign cmd.load     = (state == S_IDLE) && in_valid;
  assign cmd.rd_b     = (state == S_RDB);
  assign cmd.cap_a    = (state == S_RDB);
  assign cmd.cap_b    = (state == S_CAPB);
  assign cmd.exec     = (state == S_EXEC);
  assign cmd.commit   = (state == S_WB) && status.out_free;
endmodule

/* rtl/stack_machine_instruction_executor_unit.sv */
`timescale 1ns / 1ps
// Top level of the stack machine instruction executor.
// Depends on smie_pkg, smie_ctrl and smie_datapath.
//
// Executes one stack machine instruction per accepted request and returns one
// result carrying the next pc, console output, halt state and error code.
// After reset the block clears its stack and global memories, one entry per
// cycle, before in_ready rises. After a request is accepted, the two stack
// operands go through the single registered read port in turn (states S_RDA,
// S_RDB and S_CAPB), then come an execute state and a commit state, at which
// the result is registered. The next request can be accepted in the cycle
// after the commit. div and mod add a wait for the one-bit-per-cycle divider
// before the commit. The commit waits while an earlier result is still held
// in the output register. A new request is taken as soon as the previous
// result is in the output register, even while it waits to be taken.
module stack_machine_instruction_executor_unit #(
  parameter int STACK_DEPTH  = 1024,
  parameter int GLOBAL_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  mode,
  input  logic [23:0] immediate,
  input  logic [31:0] console_value,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [23:0] next_pc,
  output logic        out_valid,
  output logic [31:0] out_value,
  output logic        out_is_char,
  output logic        halted,
  output logic [2:0]  error_code
);
  import smie_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  smie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Registers, memories and arithmetic.
  smie_datapath #(
    .STACK_DEPTH  (STACK_DEPTH),
    .GLOBAL_DEPTH (GLOBAL_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (mode),
    .immediate     (immediate),
    .console_value (console_value),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .next_pc       (next_pc),
    .out_valid     (out_valid),
    .out_value     (out_value),
    .out_is_char   (out_is_char),
    .halted        (halted),
    .error_code    (error_code)
  );
endmodule

/* dv/tb_stack_machine_instruction_executor_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stack_machine_instruction_executor_unit.
// Depends on smie_pkg and the RTL; a built-in executor predicts every result.
module tb_stack_machine_instruction_executor_unit;
  import smie_pkg::*;

  localparam int STACK_DEPTH  = 1024;
  localparam int GLOBAL_DEPTH = 256;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 650;

  typedef struct {
    logic [23:0] pc;
    logic        ov;
    logic [31:0] val;
    logic        is_char;
    logic        hlt;
    logic [2:0]  err;
  } exec_result_t;

  typedef struct {
    logic [7:0]   op;
    logic [23:0]  imm;
    logic [31:0]  cv;
    bit           known;
    exec_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  mode = '0;
  logic [23:0] immediate = '0;
  logic [31:0] console_value = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [23:0] next_pc;
  logic        out_valid;
  logic [31:0] out_value;
  logic        out_is_char;
  logic        halted;
  logic [2:0]  error_code;

  // Shadow machine state.
  logic [23:0] m_pc;
  int          m_sp;
  int          m_fp;
  logic [31:0] m_stack [STACK_DEPTH];
  logic [31:0] m_glob [GLOBAL_DEPTH];
  logic        m_halted;

  exec_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;

  stack_machine_instruction_executor_unit #(
    .STACK_DEPTH(STACK_DEPTH),
    .GLOBAL_DEPTH(GLOBAL_DEPTH)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .immediate(immediate), .console_value(console_value),
    .result_valid(result_valid), .result_ready(result_ready),
    .next_pc(next_pc), .out_valid(out_valid), .out_value(out_value),
    .out_is_char(out_is_char), .halted(halted), .error_code(error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Executes one instruction on the shadow state and returns its result.
  function automatic exec_result_t execute_instr(logic [7:0] op, logic [23:0] imm,
                                                 logic [31:0] cv);
    exec_result_t r;
    longint imm_s, sa, sb, nsp, idx, q;
    int sp, fp;
    logic [23:0] nxt;
    logic [2:0] e;
    logic [31:0] a, b, x;
    r = '{default: '0};
    imm_s = longint'($signed(imm));
    sp = m_sp;
    fp = m_fp;
    nxt = m_pc + 24'd1;
    e = ERR_NONE;
    if (m_halted) begin
      r.pc = m_pc;
      r.hlt = 1'b1;
      return r;
    end
    case (op)
      OP_HALT: m_halted = 1'b1;
      OP_PUSHC, OP_RDINT, OP_RDCHR: begin
        x = imm_s[31:0];
        if (op == OP_RDINT) x = cv;
        if (op == OP_RDCHR) x = {{24{cv[7]}}, cv[7:0]};
        if (sp >= STACK_DEPTH) e = ERR_OVF;
        else begin
          m_stack[sp] = x;
          sp++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
      OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
        if (sp < 2) e = ERR_UNF;
        else begin
          a = m_stack[sp-1];
          b = m_stack[sp-2];
          sa = longint'($signed(a));
          sb = longint'($signed(b));
          x = '0;
          case (op)
            OP_ADD: x = b + a;
            OP_SUB: x = b - a;
            OP_MUL: x = b * a;
            OP_DIV, OP_MOD: begin
              if (a == 0) e = ERR_DIVZ;
              else begin
                q = (op == OP_DIV) ? sb / sa : sb % sa;
                x = q[31:0];
              end
            end
            OP_EQ: x = 32'(sb == sa);
            OP_NE: x = 32'(sb != sa);
            OP_LT: x = 32'(sb < sa);
            OP_LE: x = 32'(sb <= sa);
            OP_GT: x = 32'(sb > sa);
            default: x = 32'(sb >= sa);
          endcase
          if (e == ERR_NONE) begin
            m_stack[sp-2] = x;
            sp--;
          end
        end
      end
      OP_WRINT, OP_WRCHR: begin
        if (sp < 1) e = ERR_UNF;
        else begin
          sp--;
          x = m_stack[sp];
          r.ov = 1'b1;
          r.is_char = (op == OP_WRCHR);
          r.val = r.is_char ? {24'd0, x[7:0]} : x;
        end
      end
      OP_PUSHG: begin
        if (imm_s < 0 || imm_s >= GLOBAL_DEPTH) e = ERR_GLOB;
        else if (sp >= STACK_DEPTH) e = ERR_OVF;
        else begin
          m_stack[sp] = m_glob[imm_s];
          sp++;
        end
      end
      OP_POPG: begin
        if (sp < 1) e = ERR_UNF;
        else if (imm_s < 0 || imm_s >= GLOBAL_DEPTH) e = ERR_GLOB;
        else begin
          sp--;
          m_glob[imm_s] = m_stack[sp];
        end
      end
      OP_ASF: begin
        nsp = longint'(sp) + 1 + imm_s;
        if (sp >= STACK_DEPTH || nsp > STACK_DEPTH) e = ERR_OVF;
        else if (nsp < 0) e = ERR_UNF;
        else begin
          m_stack[sp] = fp;
          fp = sp + 1;
          sp = int'(nsp);
        end
      end
      OP_RSF: begin
        if (fp < 1) e = ERR_UNF;
        else begin
          q = longint'($signed(m_stack[fp-1]));
          if (q < 0) e = ERR_UNF;
          else if (q > STACK_DEPTH) e = ERR_OVF;
          else begin
            sp = fp - 1;
            fp = int'(q);
          end
        end
      end
      OP_PUSHL, OP_POPL: begin
        idx = longint'(fp) + imm_s;
        if (op == OP_PUSHL && sp >= STACK_DEPTH) e = ERR_OVF;
        else if (op == OP_POPL && sp < 1) e = ERR_UNF;
        else if (idx < 0) e = ERR_UNF;
        else if (idx >= STACK_DEPTH) e = ERR_OVF;
        else if (op == OP_PUSHL) begin
          m_stack[sp] = m_stack[idx];
          sp++;
        end else begin
          sp--;
          m_stack[idx] = m_stack[sp];
        end
      end
      OP_JMP: nxt = imm;
      OP_BRF, OP_BRT: begin
        if (sp < 1) e = ERR_UNF;
        else begin
          sp--;
          x = m_stack[sp];
          if ((op == OP_BRF && x == 0) || (op == OP_BRT && x == 1)) nxt = imm;
        end
      end
      default: ;
    endcase
    m_pc = nxt;
    if (e != ERR_NONE) begin
      m_halted = 1'b1;
      r.ov = 1'b0;
      r.val = '0;
      r.is_char = 1'b0;
    end else begin
      m_sp = sp;
      m_fp = fp;
    end
    r.pc = m_pc;
    r.hlt = m_halted;
    r.err = e;
    return r;
  endfunction

  // Offers one request, with random idle cycles in front of it.
  task automatic send_request(logic [7:0] op, logic [23:0] imm, logic [31:0] cv,
                              exec_result_t res);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    pending_results.push_back(res);
    in_valid <= 1'b1;
    mode <= op;
    immediate <= imm;
    console_value <= cv;
    do @(posedge clk); while (!in_ready);
  endtask

  // Builds a random instruction that does not trap, and sends it.
  task automatic send_random_legal();
    logic [7:0] op;
    logic [23:0] imm;
    logic [31:0] cv;
    logic [23:0] saved_pc;
    logic saved_halt;
    exec_result_t r;
    bit done;
    done = 0;
    while (!done) begin
      if ($urandom_range(99) < 6) op = 8'($urandom_range(26, 255));
      else op = 8'($urandom_range(1, 25));
      // Keep the stack shallow so pops and frames stay likely to succeed.
      if (m_sp > 48 && op inside {OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHG, OP_ASF, OP_PUSHL}
          && $urandom_range(3) != 0) continue;
      case (op)
        OP_PUSHC: imm = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(5)) - 24'd2;
        OP_PUSHG, OP_POPG: imm = 24'($urandom_range(GLOBAL_DEPTH - 1));
        OP_ASF: imm = 24'($urandom_range(5)) - 24'd1;
        OP_PUSHL, OP_POPL: imm = 24'($urandom_range(6)) - 24'd3;
        default: imm = 24'($urandom);
      endcase
      case ($urandom_range(9))
        0: cv = 32'h8000_0000;
        1: cv = 32'($urandom_range(3)) - 32'd1;
        default: cv = $urandom;
      endcase
      saved_pc = m_pc;
      saved_halt = m_halted;
      r = execute_instr(op, imm, cv);
      // A trap touches only pc and halt, so it can be undone here.
      if (r.err != ERR_NONE) begin
        m_pc = saved_pc;
        m_halted = saved_halt;
      end else done = 1;
    end
    send_request(op, imm, cv, r);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, field, got, want);
    errors++;
  endtask

  // Receiver: random stalls plus a long hold-off whenever hold_requests changes.
  int holds_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_requests != holds_seen) begin
      holds_seen = hold_requests;
      hold_left = 300;
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    exec_result_t w;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        w = pending_results.pop_front();
        if (next_pc !== w.pc) report_mismatch("next_pc", 32'(next_pc), 32'(w.pc));
        if (out_valid !== w.ov) report_mismatch("out_valid", 32'(out_valid), 32'(w.ov));
        if (out_value !== w.val) report_mismatch("out_value", out_value, w.val);
        if (out_is_char !== w.is_char)
          report_mismatch("out_is_char", 32'(out_is_char), 32'(w.is_char));
        if (halted !== w.hlt) report_mismatch("halted", 32'(halted), 32'(w.hlt));
        if (error_code !== w.err) report_mismatch("error_code", 32'(error_code), 32'(w.err));
      end
    end
  end

  // Directed program: a spread of opcodes, operand extremes and the divide corner cases.
  stim_row_t directed[$];

  function automatic stim_row_t row(logic [7:0] op, logic [23:0] imm, logic [31:0] cv);
    stim_row_t s;
    s = '{op: op, imm: imm, cv: cv, known: 0, res: '{default: '0}};
    return s;
  endfunction

  function automatic stim_row_t known_row(logic [7:0] op, logic [23:0] imm, logic [31:0] cv,
                                         exec_result_t res);
    stim_row_t s;
    s = row(op, imm, cv);
    s.known = 1;
    s.res = res;
    return s;
  endfunction

  initial begin
    stim_row_t s;
    exec_result_t r;
    logic [7:0] trap_op;
    int kind;

    m_pc = '0;
    m_sp = 0;
    m_fp = 0;
    m_halted = 1'b0;
    foreach (m_stack[i]) m_stack[i] = '0;
    foreach (m_glob[i]) m_glob[i] = '0;

    // Most negative over -1 wraps; the same under mod gives zero.
    directed.push_back(row(OP_RDINT, '0, 32'h8000_0000));
    directed.push_back(row(OP_PUSHC, 24'hFF_FFFF, '0));
    directed.push_back(row(OP_DIV, '0, '0));
    directed.push_back(known_row(OP_WRINT, '0, '0,
                                 '{24'd4, 1'b1, 32'h8000_0000, 1'b0, 1'b0, ERR_NONE}));
    directed.push_back(row(OP_RDINT, '0, 32'h8000_0000));
    directed.push_back(row(OP_PUSHC, 24'hFF_FFFF, '0));
    directed.push_back(row(OP_MOD, '0, '0));
    directed.push_back(row(OP_POPG, 24'd255, 32'hFFFF_FFFF));
    // Globals, sign-extended characters and the widest immediates.
    directed.push_back(row(OP_PUSHG, 24'd255, '0));
    directed.push_back(row(OP_RDCHR, '0, 32'h7FFF_FFF5));
    directed.push_back(row(OP_ADD, '0, '0));
    directed.push_back(known_row(OP_WRCHR, '0, '0,
                                 '{24'd12, 1'b1, 32'h0000_00F5, 1'b1, 1'b0, ERR_NONE}));
    directed.push_back(row(OP_ASF, 24'd2, '0));
    directed.push_back(row(OP_PUSHC, 24'h7F_FFFF, '0));
    directed.push_back(row(OP_POPL, 24'd1, '0));
    directed.push_back(row(OP_PUSHL, 24'd1, '0));
    directed.push_back(row(OP_PUSHC, 24'h80_0000, '0));
    directed.push_back(row(OP_MUL, '0, '0));
    directed.push_back(row(OP_RSF, '0, '0));
    directed.push_back(row(OP_PUSHC, 24'd1, '0));
    directed.push_back(row(OP_BRT, 24'hFF_FFFF, '0));
    directed.push_back(known_row(OP_JMP, '0, '0,
                                 '{24'd0, 1'b0, 32'd0, 1'b0, 1'b0, ERR_NONE}));
    directed.push_back(row(8'hFF, 24'hFF_FFFF, '0));
    directed.push_back(row(OP_PUSHC, '0, '0));
    directed.push_back(row(OP_BRF, 24'h00_0123, '0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 31;
    rx_idle_pct = 83;
    foreach (directed[i]) begin
      s = directed[i];
      r = execute_instr(s.op, s.imm, s.cv);
      send_request(s.op, s.imm, s.cv, s.known ? s.res : r);
    end

    // Random program in three idling phases.
    repeat (RANDOM_ITEMS) send_random_legal();
    tx_idle_pct = 83;
    rx_idle_pct = 31;
    repeat (RANDOM_ITEMS) send_random_legal();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_requests++;
    repeat (RANDOM_ITEMS) send_random_legal();

    // Let the block drain, then end the program with one randomly chosen trap.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    kind = $urandom_range(1, 4);
    case (kind)
      1: begin
        repeat (2) begin
          r = execute_instr(OP_PUSHC, '0, '0);
          send_request(OP_PUSHC, '0, '0, r);
        end
        trap_op = $urandom_range(1) ? OP_DIV : OP_MOD;
        r = execute_instr(trap_op, '0, '0);
        r.err = ERR_DIVZ;
        send_request(trap_op, '0, '0, r);
      end
      2: begin
        r = execute_instr(OP_PUSHL, 24'h7F_FFFF, '0);
        r.err = ERR_OVF;
        send_request(OP_PUSHL, 24'h7F_FFFF, '0, r);
      end
      3: begin
        r = execute_instr(OP_PUSHC, 24'd9, '0);
        send_request(OP_PUSHC, 24'd9, '0, r);
        r = execute_instr(OP_POPL, 24'h80_0000, '0);
        r.err = ERR_UNF;
        send_request(OP_POPL, 24'h80_0000, '0, r);
      end
      default: begin
        r = execute_instr(OP_PUSHG, 24'd256, '0);
        r.err = ERR_GLOB;
        send_request(OP_PUSHG, 24'd256, '0, r);
      end
    endcase
    // A stopped machine only repeats its pc.
    repeat (8) begin
      trap_op = 8'($urandom);
      r = execute_instr(trap_op, 24'($urandom), $urandom);
      send_request(trap_op, 24'($urandom), $urandom, r);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/smie_pkg.sv
rtl/smie_ram.sv
rtl/smie_div.sv
rtl/smie_datapath.sv
rtl/smie_ctrl.sv
rtl/stack_machine_instruction_executor_unit.sv
dv/tb_stack_machine_instruction_executor_unit.sv
